### src/stkb_pkg.sv
// shared constants, types and the twiddle octant table for the stockham butterfly
package stkb_pkg;

  localparam int LOG2_POINTS = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = LOG2_POINTS - 1;
  localparam int OPOS_BITS   = LOG2_POINTS;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int SPAN_BITS   = 4;
  localparam int TW_FRAC     = 15;
  localparam int TW_BITS     = TW_FRAC + 2;
  localparam int TW_MAG_BITS = TW_FRAC + 1;
  localparam int PROD_BITS   = TW_BITS + OUT_BITS;

  // one octant of the unit circle, both ends included
  localparam int OCT_ENTRIES  = 2 ** (LOG2_POINTS - 3) + 1;
  localparam int OCT_IDX_BITS = $clog2(OCT_ENTRIES);

  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = SPAN_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN_LOG2 = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE   = 1'b1;

  localparam logic [63:0] Q30_ONE = 64'h4000_0000;
  localparam logic [63:0] PI_Q31  = 64'd6746518852;

  typedef logic [OCT_ENTRIES-1:0][2*TW_MAG_BITS-1:0] oct_rom_t;

  typedef struct packed {
    logic prod;
    logic res;
  } stage_en_t;

  function automatic logic [63:0] horner_sin(input logic [63:0] x2);
    logic [63:0] t;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 156;
    t = Q30_ONE - ((x2 * t) >> 30) / 110;
    t = Q30_ONE - ((x2 * t) >> 30) / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    return t;
  endfunction

  function automatic logic [63:0] horner_cos(input logic [63:0] x2);
    logic [63:0] t;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 132;
    t = Q30_ONE - ((x2 * t) >> 30) / 90;
    t = Q30_ONE - ((x2 * t) >> 30) / 56;
    t = Q30_ONE - ((x2 * t) >> 30) / 30;
    t = Q30_ONE - ((x2 * t) >> 30) / 12;
    t = Q30_ONE - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  // entry m holds {cos, sin} of 2*pi*m/N, rounded to 15 fraction bits
  function automatic oct_rom_t tw_build();
    oct_rom_t    rom;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] cr;
    logic [63:0] sr;
    for (int m = 0; m < OCT_ENTRIES; m++) begin
      r  = 64'(m) << (32 - LOG2_POINTS);
      x  = (r * PI_Q31 + 64'h8000_0000) >> 32;
      x2 = (x * x) >> 30;
      s  = (x * horner_sin(x2)) >> 30;
      c  = horner_cos(x2);
      cr = (c + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
      sr = (s + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
      rom[m] = {cr[TW_MAG_BITS-1:0], sr[TW_MAG_BITS-1:0]};
    end
    return rom;
  endfunction

  localparam oct_rom_t TW_OCT = tw_build();

endpackage

### src/stkb_twiddle_rom.sv
// twiddle lookup: octant table, symmetry folding and direction sign, registered
module stkb_twiddle_rom (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [stkb_pkg::POS_BITS-1:0]       idx_i,
  input  logic                                inv_i,
  output logic signed [stkb_pkg::TW_BITS-1:0] wr_o,
  output logic signed [stkb_pkg::TW_BITS-1:0] wi_o
);
  import stkb_pkg::*;

  localparam int LOW_BITS = POS_BITS - 1;

  logic [LOW_BITS-1:0]          low;
  logic                         upper_quad;
  logic                         swap;
  logic [LOW_BITS:0]            fold;
  logic [OCT_IDX_BITS-1:0]      oct_idx;
  logic [2*TW_MAG_BITS-1:0]     entry;
  logic signed [TW_BITS-1:0]    cos_v;
  logic signed [TW_BITS-1:0]    sin_v;
  logic signed [TW_BITS-1:0]    wr_d;
  logic signed [TW_BITS-1:0]    wi_d;
  logic signed [TW_BITS-1:0]    wi_fwd;
  logic signed [TW_BITS-1:0]    wr_q;
  logic signed [TW_BITS-1:0]    wi_q;

  always_comb begin
    low        = idx_i[LOW_BITS-1:0];
    upper_quad = idx_i[POS_BITS-1];
    // past the quadrant midpoint (the octant end), mirror and exchange cos and sin
    swap       = low > LOW_BITS'(OCT_ENTRIES - 1);
    fold       = swap ? ((LOW_BITS+1)'(1) << LOW_BITS) - {1'b0, low} : {1'b0, low};
    oct_idx    = fold[OCT_IDX_BITS-1:0];
    entry      = TW_OCT[oct_idx];
    if (swap) begin
      cos_v = $signed({1'b0, entry[TW_MAG_BITS-1:0]});
      sin_v = $signed({1'b0, entry[2*TW_MAG_BITS-1:TW_MAG_BITS]});
    end else begin
      cos_v = $signed({1'b0, entry[2*TW_MAG_BITS-1:TW_MAG_BITS]});
      sin_v = $signed({1'b0, entry[TW_MAG_BITS-1:0]});
    end
    if (upper_quad) begin
      wr_d   = -sin_v;
      wi_fwd = cos_v;
    end else begin
      wr_d   = cos_v;
      wi_fwd = sin_v;
    end
    wi_d = inv_i ? -wi_fwd : wi_fwd;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wr_q <= wr_d;
      wi_q <= wi_d;
    end
  end

  assign wr_o = wr_q;
  assign wi_o = wi_q;

endmodule

### src/stkb_cmul.sv
// complex rotation: registered partial products, then combine, round and saturate
module stkb_cmul (
  input  logic                                 clk_i,
  input  stkb_pkg::stage_en_t                  en_i,
  input  logic signed [stkb_pkg::TW_BITS-1:0]  wr_i,
  input  logic signed [stkb_pkg::TW_BITS-1:0]  wi_i,
  input  logic signed [stkb_pkg::OUT_BITS-1:0] dr_i,
  input  logic signed [stkb_pkg::OUT_BITS-1:0] di_i,
  output logic signed [stkb_pkg::OUT_BITS-1:0] re_o,
  output logic signed [stkb_pkg::OUT_BITS-1:0] im_o
);
  import stkb_pkg::*;

  localparam int SUM_BITS = PROD_BITS + 1;
  localparam int RS_BITS  = SUM_BITS - TW_FRAC;
  localparam logic signed [SUM_BITS-1:0] RND_HALF = SUM_BITS'(1) << (TW_FRAC - 1);

  logic signed [PROD_BITS-1:0] rr_q, ii_q, ir_q, ri_q;
  logic signed [PROD_BITS-1:0] rr_d, ii_d, ir_d, ri_d;
  logic signed [SUM_BITS-1:0]  re_full, im_full;
  logic signed [OUT_BITS-1:0]  re_d, im_d;
  logic signed [OUT_BITS-1:0]  re_q, im_q;

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [RS_BITS-1:0] v);
    logic [RS_BITS-OUT_BITS:0] top;
    top = v[RS_BITS-1:OUT_BITS-1];
    if ((&top) || !(|top)) begin
      return v[OUT_BITS-1:0];
    end else if (v[RS_BITS-1]) begin
      return {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    rr_d = wr_i * dr_i;
    ii_d = wi_i * di_i;
    ir_d = wi_i * dr_i;
    ri_d = wr_i * di_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ir_q <= ir_d;
      ri_q <= ri_d;
    end
  end

  // round half up, then clamp to the output range
  always_comb begin
    re_full = SUM_BITS'(rr_q) - SUM_BITS'(ii_q) + RND_HALF;
    im_full = SUM_BITS'(ir_q) + SUM_BITS'(ri_q) + RND_HALF;
    re_d    = sat(re_full[SUM_BITS-1:TW_FRAC]);
    im_d    = sat(im_full[SUM_BITS-1:TW_FRAC]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      re_q <= re_d;
      im_q <= im_d;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

### src/stockham_radix2_stage_butterfly_top.sv
// Radix-2 Stockham FFT stage butterfly: a four-stage pipeline that takes one pair per
// cycle and returns c = a + b, d = w * (a - b) and the output position. An accepted
// pair moves through the stages in order and leaves from stage four; with out_ready_i
// held high the block sustains one transfer per clock. Stage one splits the position by
// the span and forms sum and difference, stage two reads the twiddle from a 129-entry
// octant table built at elaboration and folded by symmetry, stage three forms the four
// 17x17 partial products, stage four combines, rounds and saturates. Each stage holds its
// item until the next one frees, so a stall loses nothing and bubbles close up.
// span_log2 and inverse_direction are written through the cfg port; the user must write them only
// while the pipeline is empty, as the block does not enforce this. They take effect for the next transfer.
module stockham_radix2_stage_butterfly_top (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [stkb_pkg::CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  logic [stkb_pkg::CFG_DATA_BITS-1:0]        cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [stkb_pkg::POS_BITS-1:0]             pos_in_half_i,
  input  logic signed [stkb_pkg::SAMPLE_BITS-1:0]   a_re_i,
  input  logic signed [stkb_pkg::SAMPLE_BITS-1:0]   a_im_i,
  input  logic signed [stkb_pkg::SAMPLE_BITS-1:0]   b_re_i,
  input  logic signed [stkb_pkg::SAMPLE_BITS-1:0]   b_im_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [stkb_pkg::OPOS_BITS-1:0]            out_pos_o,
  output logic signed [stkb_pkg::OUT_BITS-1:0]      sum_re_o,
  output logic signed [stkb_pkg::OUT_BITS-1:0]      sum_im_o,
  output logic signed [stkb_pkg::OUT_BITS-1:0]      diff_rot_re_o,
  output logic signed [stkb_pkg::OUT_BITS-1:0]      diff_rot_im_o
);
  import stkb_pkg::*;

  logic [SPAN_BITS-1:0] span_q;
  logic                 inv_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [POS_BITS-1:0]        lo_mask;
  logic [POS_BITS-1:0]        jw_d;
  logic [OPOS_BITS-1:0]       opos_d;
  logic signed [OUT_BITS-1:0] sre_d, sim_d, dre_d, dim_d;

  logic [POS_BITS-1:0]        jw1_q;
  logic                       inv1_q;
  logic [OPOS_BITS-1:0]       opos1_q, opos2_q, opos3_q, opos4_q;
  logic signed [OUT_BITS-1:0] sre1_q, sre2_q, sre3_q, sre4_q;
  logic signed [OUT_BITS-1:0] sim1_q, sim2_q, sim3_q, sim4_q;
  logic signed [OUT_BITS-1:0] dre1_q, dre2_q;
  logic signed [OUT_BITS-1:0] dim1_q, dim2_q;

  logic signed [TW_BITS-1:0]  wr2, wi2;
  stage_en_t                  mul_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      inv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPAN_LOG2: span_q <= cfg_wdata_i[SPAN_BITS-1:0];
        REG_INVERSE:   inv_q  <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // a stage takes a new item when it is empty or its item moves on
  always_comb begin
    rdy4 = !v4_q || out_ready_i;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    v4_d = rdy4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // bits below the span stay as k, bits at and above it move up one as j
  always_comb begin
    for (int i = 0; i < POS_BITS; i++) begin
      lo_mask[i] = (SPAN_BITS+1)'(i) < {1'b0, span_q};
    end
    jw_d   = pos_in_half_i & ~lo_mask;
    opos_d = {jw_d, 1'b0} | {1'b0, pos_in_half_i & lo_mask};
    sre_d  = OUT_BITS'(a_re_i) + OUT_BITS'(b_re_i);
    sim_d  = OUT_BITS'(a_im_i) + OUT_BITS'(b_im_i);
    dre_d  = OUT_BITS'(a_re_i) - OUT_BITS'(b_re_i);
    dim_d  = OUT_BITS'(a_im_i) - OUT_BITS'(b_im_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      jw1_q   <= jw_d;
      inv1_q  <= inv_q;
      opos1_q <= opos_d;
      sre1_q  <= sre_d;
      sim1_q  <= sim_d;
      dre1_q  <= dre_d;
      dim1_q  <= dim_d;
    end
    if (rdy2) begin
      opos2_q <= opos1_q;
      sre2_q  <= sre1_q;
      sim2_q  <= sim1_q;
      dre2_q  <= dre1_q;
      dim2_q  <= dim1_q;
    end
    if (rdy3) begin
      opos3_q <= opos2_q;
      sre3_q  <= sre2_q;
      sim3_q  <= sim2_q;
    end
    if (rdy4) begin
      opos4_q <= opos3_q;
      sre4_q  <= sre3_q;
      sim4_q  <= sim3_q;
    end
  end

  stkb_twiddle_rom u_rom (
    .clk_i (clk_i),
    .en_i  (rdy2),
    .idx_i (jw1_q),
    .inv_i (inv1_q),
    .wr_o  (wr2),
    .wi_o  (wi2)
  );

  assign mul_en.prod = rdy3;
  assign mul_en.res  = rdy4;

  stkb_cmul u_cmul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .wr_i  (wr2),
    .wi_i  (wi2),
    .dr_i  (dre2_q),
    .di_i  (dim2_q),
    .re_o  (diff_rot_re_o),
    .im_o  (diff_rot_im_o)
  );

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;
  assign out_pos_o   = opos4_q;
  assign sum_re_o    = sre4_q;
  assign sum_im_o    = sim4_q;

endmodule

### dv/stockham_radix2_stage_butterfly_top_test.sv
// self-checking testbench for the radix-2 stockham stage butterfly
`timescale 1ns / 1ps

module stockham_radix2_stage_butterfly_top_test;
  import stkb_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [63:0] UNIT_Q30    = 64'h4000_0000;
  localparam logic [63:0] PI_Q31_K    = 64'd6746518852;
  localparam longint      ROT_MAX     = (64'sd1 << SAMPLE_BITS) - 1;
  localparam longint      ROT_MIN     = -(64'sd1 << SAMPLE_BITS);

  typedef struct {
    logic [OPOS_BITS-1:0]       pos;
    logic signed [OUT_BITS-1:0] sum_re;
    logic signed [OUT_BITS-1:0] sum_im;
    logic signed [OUT_BITS-1:0] rot_re;
    logic signed [OUT_BITS-1:0] rot_im;
  } bfly_out_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_idx_i     = REG_SPAN_LOG2;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i   = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [POS_BITS-1:0]           pos_in_half_i = '0;
  logic signed [SAMPLE_BITS-1:0] a_re_i        = '0;
  logic signed [SAMPLE_BITS-1:0] a_im_i        = '0;
  logic signed [SAMPLE_BITS-1:0] b_re_i        = '0;
  logic signed [SAMPLE_BITS-1:0] b_im_i        = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [OPOS_BITS-1:0]          out_pos_o;
  logic signed [OUT_BITS-1:0]    sum_re_o;
  logic signed [OUT_BITS-1:0]    sum_im_o;
  logic signed [OUT_BITS-1:0]    diff_rot_re_o;
  logic signed [OUT_BITS-1:0]    diff_rot_im_o;

  // local copy of the stage configuration
  logic [SPAN_BITS-1:0] cfg_span    = '0;
  logic                 cfg_inverse = 1'b0;

  bfly_out_t due_outputs[$];
  int        mismatches     = 0;
  int        cycles         = 0;
  int        send_gap_max   = 13;
  int        recv_stall_max = 13;
  int        hold_cycles    = 0;

  stockham_radix2_stage_butterfly_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_in_half_i (pos_in_half_i),
    .a_re_i        (a_re_i),
    .a_im_i        (a_im_i),
    .b_re_i        (b_re_i),
    .b_im_i        (b_im_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_pos_o     (out_pos_o),
    .sum_re_o      (sum_re_o),
    .sum_im_o      (sum_im_o),
    .diff_rot_re_o (diff_rot_re_o),
    .diff_rot_im_o (diff_rot_im_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stockham_radix2_stage_butterfly_top test failed");
      $finish;
    end
  end

  // truncating taylor series in q30; term n divides by (2n)(2n+1) for sin, (2n-1)(2n) for cos
  function automatic logic [63:0] taylor_q30(input logic [63:0] x2, input bit want_sin);
    logic [63:0] acc;
    logic [63:0] den;
    acc = UNIT_Q30;
    for (int n = 6; n >= 1; n--) begin
      den = want_sin ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * 2 * n);
      acc = UNIT_Q30 - ((x2 * acc) >> 30) / den;
    end
    return acc;
  endfunction

  function automatic void unit_root(input logic [POS_BITS-1:0] idx,
                                    output longint w_re, output longint w_im);
    logic [31:0] phase;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sin_q15;
    logic [63:0] cos_q15;
    logic [63:0] tmp;
    bit          fold;
    phase   = 32'(idx) << (32 - LOG2_POINTS);
    r       = 64'(phase[29:0]);
    fold    = r > 64'h2000_0000;
    if (fold) r = 64'h4000_0000 - r;
    x       = (r * PI_Q31_K + 64'h8000_0000) >> 32;
    x2      = (x * x) >> 30;
    sin_q15 = (((x * taylor_q30(x2, 1'b1)) >> 30) + 64'd16384) >> 15;
    cos_q15 = (taylor_q30(x2, 1'b0) + 64'd16384) >> 15;
    // upper half of the quadrant mirrors around 45 degrees
    if (fold) begin
      tmp     = cos_q15;
      cos_q15 = sin_q15;
      sin_q15 = tmp;
    end
    case (phase[31:30])
      2'd0: begin w_re =  longint'(cos_q15); w_im =  longint'(sin_q15); end
      2'd1: begin w_re = -longint'(sin_q15); w_im =  longint'(cos_q15); end
      2'd2: begin w_re = -longint'(cos_q15); w_im = -longint'(sin_q15); end
      default: begin w_re = longint'(sin_q15); w_im = -longint'(cos_q15); end
    endcase
  endfunction

  function automatic logic signed [OUT_BITS-1:0] round_clip(input longint v);
    longint q;
    q = (v + 64'sd16384) >>> 15;
    if (q > ROT_MAX) q = ROT_MAX;
    if (q < ROT_MIN) q = ROT_MIN;
    return OUT_BITS'(q);
  endfunction

  function automatic bfly_out_t butterfly_of(input logic [POS_BITS-1:0] pos,
                                             input logic signed [SAMPLE_BITS-1:0] ar,
                                             input logic signed [SAMPLE_BITS-1:0] ai,
                                             input logic signed [SAMPLE_BITS-1:0] br,
                                             input logic signed [SAMPLE_BITS-1:0] bi);
    bfly_out_t           res;
    logic [POS_BITS-1:0] grp;
    logic [POS_BITS-1:0] ofs;
    logic [POS_BITS-1:0] tw_idx;
    longint              a_r, a_i, b_r, b_i, d_r, d_i, w_re, w_im;
    grp    = pos >> cfg_span;
    ofs    = pos & POS_BITS'((32'd1 << cfg_span) - 1);
    tw_idx = POS_BITS'(32'(grp) << cfg_span);
    a_r = ar;
    a_i = ai;
    b_r = br;
    b_i = bi;
    d_r = a_r - b_r;
    d_i = a_i - b_i;
    unit_root(tw_idx, w_re, w_im);
    if (cfg_inverse) w_im = -w_im;
    res.pos    = OPOS_BITS'((32'(grp) << (cfg_span + 1)) + 32'(ofs));
    res.sum_re = OUT_BITS'(a_r + b_r);
    res.sum_im = OUT_BITS'(a_i + b_i);
    res.rot_re = round_clip(w_re * d_r - w_im * d_i);
    res.rot_im = round_clip(w_im * d_r + w_re * d_i);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    bfly_out_t want;
    if (due_outputs.size() == 0) begin
      $display("%0t: out_pos mismatch, expected none, actual %0d", $time, out_pos_o);
      mismatches++;
    end else begin
      want = due_outputs.pop_front();
      compare_field("out_pos", 32'(want.pos), 32'(out_pos_o));
      compare_field("sum_re", want.sum_re, sum_re_o);
      compare_field("sum_im", want.sum_im, sum_im_o);
      compare_field("diff_rot_re", want.rot_re, diff_rot_re_o);
      compare_field("diff_rot_im", want.rot_im, diff_rot_im_o);
    end
  endtask

  // result side: random stalls per transfer, plus a long hold-off on request
  initial begin : drain_outputs
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      stall = 0;
      if (out_valid_o && out_ready_i) begin
        check_result();
        stall = $urandom_range(0, recv_stall_max);
      end
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_pair(input logic [POS_BITS-1:0] pos,
                           input logic signed [SAMPLE_BITS-1:0] ar,
                           input logic signed [SAMPLE_BITS-1:0] ai,
                           input logic signed [SAMPLE_BITS-1:0] br,
                           input logic signed [SAMPLE_BITS-1:0] bi);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pos_in_half_i <= pos;
    a_re_i        <= ar;
    a_im_i        <= ai;
    b_re_i        <= br;
    b_im_i        <= bi;
    do @(posedge clk_i); while (!in_ready_o);
    due_outputs.push_back(butterfly_of(pos, ar, ai, br, bi));
  endtask

  // every pair yields one result, so an empty store means an empty pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_SPAN_LOG2) cfg_span = data;
    else cfg_inverse = data[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_stage(input int span, input bit inv);
    write_reg(REG_SPAN_LOG2, CFG_DATA_BITS'(span));
    write_reg(REG_INVERSE, CFG_DATA_BITS'(inv));
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [POS_BITS-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return POS_BITS'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    set_stage(0, 1'b0);
    // unit twiddle with full-scale difference and full-scale negative sum, then a zero difference at position 511
    send_pair(0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_pair(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_pair(511, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    // 45 degree twiddle drives the rotated difference into saturation
    send_pair(128, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_pair(128, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_pair(256, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_pair(256, 16'sh1234, -16'sh0abc, 16'sh7fff, 16'sh8000);
    send_pair(384, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_pair(1, 16'sh0001, -16'sh0001, -16'sh0001, 16'sh0001);
    settle();
    set_stage(0, 1'b1);
    send_pair(128, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_pair(1, 16'sh0001, -16'sh0001, -16'sh0001, 16'sh0001);
    send_pair(511, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
    settle();
    // large span: group is always zero and the twiddle is one
    set_stage(9, 1'b0);
    send_pair(511, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_pair(0, 16'sh4000, 16'sh4000, -16'sh4000, 16'sh0000);
    send_pair(300, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    settle();
    set_stage(5, 1'b1);
    send_pair(37, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000);
    send_pair(511, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh8000);
    settle();
    // top group puts the output position in the upper half of the array
    set_stage(8, 1'b0);
    send_pair(255, 16'sh2000, -16'sh2000, 16'sh1000, 16'sh3000);
    send_pair(256, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    settle();
  endtask

  task automatic test_random_stages();
    for (int ph = 0; ph < 10; ph++) begin
      set_stage(ph, 1'($urandom));
      send_gap_max   = (ph % 3 == 0) ? 0 : 13;
      recv_stall_max = (ph % 4 == 1) ? 0 : 13;
      repeat (95) send_pair(rand_pos(), rand_sample(), rand_sample(), rand_sample(),
                            rand_sample());
      settle();
    end
  endtask

  task automatic test_backpressure();
    set_stage(3, 1'b1);
    send_gap_max   = 0;
    recv_stall_max = 2;
    hold_cycles    = 250;
    repeat (60) send_pair(rand_pos(), rand_sample(), rand_sample(), rand_sample(),
                          rand_sample());
    settle();
    send_gap_max   = 13;
    recv_stall_max = 13;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stages();
    test_backpressure();
    settle();
    if (mismatches == 0) begin
      $display("stockham_radix2_stage_butterfly_top test passed");
    end else begin
      $display("stockham_radix2_stage_butterfly_top test failed");
    end
    $finish;
  end

endmodule

### files.f
src/stkb_pkg.sv
src/stkb_twiddle_rom.sv
src/stkb_cmul.sv
src/stockham_radix2_stage_butterfly_top.sv
dv/stockham_radix2_stage_butterfly_top_test.sv
